@@ rtl/core/mdng_pkg.sv @@
// ----------------------------------------------------------------------------
// mdng_pkg
// Shared types and constants of the microphone DC blocker and noise gate.
// ----------------------------------------------------------------------------
package mdng_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int LEN_W     = 11;
	localparam int COEF_W    = 16;
	localparam int DC_W      = 32;
	localparam int SUM_W     = 41;
	localparam int FLOOR_W   = 48;
	localparam int DIV_W     = SUM_W + 16;
	localparam int ROOT_W    = (DIV_W + 1) / 2;
	localparam int SQ_W      = 2 * ROOT_W;
	localparam int REM_W     = ROOT_W + 2;
	localparam int CNT_W     = $clog2(DIV_W);
	localparam int R16_W     = ROOT_W + 8;
	localparam int R24_W     = ROOT_W + 16;
	localparam int MUL_A_W   = FLOOR_W + 1;
	localparam int MUL_B_W   = COEF_W + 1;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int THR_W     = FLOOR_W + COEF_W + 1;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam logic [FLOOR_W-1:0] FLOOR_MAX = {FLOOR_W{1'b1}};
	localparam logic [THR_W-1:0]   GATE_BIAS = THR_W'(64'd16 << 24);

	localparam logic [COEF_W-1:0] RST_DC_COEF     = 16'd328;
	localparam logic [COEF_W-1:0] RST_GAIN        = 16'd64;
	localparam logic [COEF_W-1:0] RST_GATE_RATIO  = 16'd1280;
	localparam logic [COEF_W-1:0] RST_FLOOR_CREEP = 16'd131;
	localparam logic [LEN_W-1:0]  RST_FRAME_LEN   = 11'd547;

	typedef enum logic [2:0] {
		REG_DC_COEF,
		REG_GAIN,
		REG_GATE_RATIO,
		REG_FLOOR_CREEP,
		REG_FRAME_LENGTH
	} reg_idx_t;

	typedef struct packed {
		logic [COEF_W-1:0] dc_coef;
		logic [COEF_W-1:0] gain;
		logic [COEF_W-1:0] gate_ratio;
		logic [COEF_W-1:0] floor_creep;
		logic [LEN_W-1:0]  frame_length;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] raw_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] clean_sample;
		logic                       gated;
		logic                       frame_last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TRACK,
		ST_TRACK_ADD,
		ST_GAIN,
		ST_SCALE,
		ST_SQUARE,
		ST_EMIT,
		ST_DIV_GO,
		ST_ROOT,
		ST_FLOOR,
		ST_CREEP,
		ST_GATE_MUL,
		ST_DECIDE
	} state_t;

	typedef enum logic [1:0] {
		RD_IDLE,
		RD_DIV,
		RD_SQRT
	} rd_phase_t;

endpackage

@@ rtl/core/mdng_stream_if.sv @@
// ----------------------------------------------------------------------------
// mdng_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface mdng_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/mic_dc_block_noise_gate_top.sv @@
// ----------------------------------------------------------------------------
// mic_dc_block_noise_gate_top
// Microphone DC blocker with RMS noise gate and one frame of output delay.
// ----------------------------------------------------------------------------
// A sample's result enters the output register as it leaves ST_EMIT, after ST_TRACK,
// ST_TRACK_ADD, ST_GAIN, ST_SCALE and ST_SQUARE; the multiplier is used three times.
// A new sample is taken only in ST_IDLE, once the last one is through. With the gate
// on, a frame's last sample goes on to the divide and square root and the floor and
// gate math. After reset the frame store is cleared one entry per cycle, all MAX_FRAME
// entries, and no sample is taken until that pass ends; config writes are always taken.
// ----------------------------------------------------------------------------
module mic_dc_block_noise_gate_top #(
	parameter int MAX_FRAME = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mdng_pkg::ADDR_W-1:0] paddr,
	input  logic [mdng_pkg::DATA_W-1:0] pwdata,
	output logic [mdng_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	mdng_stream_if.sink                 sample_in,
	mdng_stream_if.source               sample_out
);
	import mdng_pkg::*;

	localparam int AW  = $clog2(MAX_FRAME);
	localparam int N_W = $clog2(MAX_FRAME + 1);
	localparam int CW  = (N_W > LEN_W) ? N_W : LEN_W;

	cfg_t cfg;

	// Control state.
	state_t                     state_q, state_d;
	logic [AW-1:0]              idx_q;
	logic [AW-1:0]              clr_q;
	logic signed [DC_W-1:0]     dc_q;
	logic [SUM_W-1:0]           sum_q;
	logic [FLOOR_W-1:0]         floor_q;
	logic                       gate_q;
	logic                       out_valid_q;

	// Payload registers.
	logic signed [SAMPLE_W-1:0] raw_q;
	logic [SAMPLE_W-1:0]        old_q;
	logic signed [SAMPLE_W-1:0] clean_q;
	logic [N_W-1:0]             n_q;
	out_item_t                  out_q;

	// Shared multiplier.
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   prod;

	// Frame store.
	logic                       ram_en, ram_we;
	logic [AW-1:0]              ram_addr;
	logic [SAMPLE_W-1:0]        ram_wdata, ram_rdata;

	// Divide and root unit.
	logic                       rd_start, rd_idle;
	logic [ROOT_W-1:0]          root;

	// Derived values.
	logic                       accept, slot_free, emit_fire;
	logic [CW-1:0]              fl_ext, len_eff, idx_next;
	logic                       is_last, gate_on;
	logic signed [DC_W:0]       d_trk;
	logic signed [PROD_W-1:0]   ybias, yq;
	logic signed [SAMPLE_W-1:0] y_sat;
	logic [SUM_W-1:0]           sum_d;
	logic [R16_W-1:0]           r16;
	logic [FLOOR_W-1:0]         r16_w, floor_gap;
	logic [R24_W-1:0]           r24;
	logic [THR_W-1:0]           thr;

	mdng_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mdng_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	mdng_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_FRAME)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	mdng_root_div #(
		.N_W (N_W)
	) u_root_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rd_start),
		.dividend ({sum_q, 16'h0000}),
		.divisor  (n_q),
		.idle     (rd_idle),
		.root     (root)
	);

	// Arithmetic around the shared multiplier. The product register always
	// holds the result of the operands chosen in the previous state.
	always_comb begin
		accept    = sample_in.valid && sample_in.ready;
		slot_free = !out_valid_q || sample_out.ready;
		emit_fire = (state_q == ST_EMIT) && slot_free;
		gate_on   = (cfg.gate_ratio != '0);

		// A zero length acts as one, a length past the store acts as the store.
		fl_ext = CW'(cfg.frame_length);
		if (fl_ext == '0) begin
			len_eff = CW'(1);
		end else if (fl_ext > CW'(MAX_FRAME)) begin
			len_eff = CW'(MAX_FRAME);
		end else begin
			len_eff = fl_ext;
		end
		idx_next = CW'(idx_q) + CW'(1);
		is_last  = (idx_next >= len_eff);

		// Distance from the tracker to the sample in Q16.16.
		d_trk = $signed({raw_q[SAMPLE_W-1], raw_q, 16'h0000}) - $signed({dc_q[DC_W-1], dc_q});

		// Scaled output: divide the Q24 product by 2^24 toward zero, then saturate.
		ybias = prod + (prod[PROD_W-1] ? PROD_W'(24'hFF_FFFF) : PROD_W'(0));
		yq    = ybias >>> 24;
		if (yq > PROD_W'(32767)) begin
			y_sat = 16'sh7FFF;
		end else if (yq < -PROD_W'(32768)) begin
			y_sat = -16'sh8000;
		end else begin
			y_sat = yq[SAMPLE_W-1:0];
		end

		sum_d     = sum_q + SUM_W'(prod[31:0]);
		r16       = {root, 8'h00};
		r16_w     = FLOOR_W'(r16);
		floor_gap = r16_w - floor_q;
		r24       = {r16, 8'h00};
		thr       = THR_W'(prod[THR_W-2:0]) + GATE_BIAS;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:     if (clr_q == AW'(MAX_FRAME - 1)) state_d = ST_IDLE;
			ST_IDLE:      if (accept) state_d = ST_TRACK;
			ST_TRACK:     state_d = ST_TRACK_ADD;
			ST_TRACK_ADD: state_d = ST_GAIN;
			ST_GAIN:      state_d = ST_SCALE;
			ST_SCALE:     state_d = ST_SQUARE;
			ST_SQUARE:    state_d = ST_EMIT;
			ST_EMIT: begin
				if (slot_free) begin
					state_d = (is_last && gate_on) ? ST_DIV_GO : ST_IDLE;
				end
			end
			ST_DIV_GO:    state_d = ST_ROOT;
			ST_ROOT:      if (rd_idle) state_d = ST_FLOOR;
			ST_FLOOR:     state_d = (r16_w < floor_q) ? ST_GATE_MUL : ST_CREEP;
			ST_CREEP:     state_d = ST_GATE_MUL;
			ST_GATE_MUL:  state_d = ST_DECIDE;
			ST_DECIDE:    state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: multiplier operands, store access, divider start.
	always_comb begin
		mul_a            = '0;
		mul_b            = '0;
		ram_en           = 1'b0;
		ram_we           = 1'b0;
		ram_addr         = idx_q;
		ram_wdata        = clean_q;
		rd_start         = 1'b0;
		sample_in.ready  = (state_q == ST_IDLE);
		sample_out.valid = out_valid_q;
		sample_out.payload = out_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				// Fetch the sample at the same place of the previous frame.
				ram_en = accept;
			end
			ST_TRACK: begin
				mul_a = MUL_A_W'(d_trk);
				mul_b = $signed({1'b0, cfg.dc_coef});
			end
			ST_GAIN: begin
				mul_a = MUL_A_W'(d_trk);
				mul_b = $signed({1'b0, cfg.gain});
			end
			ST_SQUARE: begin
				mul_a  = MUL_A_W'(clean_q);
				mul_b  = MUL_B_W'(clean_q);
				ram_en = 1'b1;
				ram_we = 1'b1;
			end
			ST_EMIT: begin
				// Keep the square in the product register while the result waits.
				mul_a = MUL_A_W'(clean_q);
				mul_b = MUL_B_W'(clean_q);
			end
			ST_DIV_GO: rd_start = 1'b1;
			ST_FLOOR: begin
				mul_a = $signed({1'b0, floor_gap});
				mul_b = $signed({1'b0, cfg.floor_creep});
			end
			ST_GATE_MUL: begin
				mul_a = $signed({1'b0, floor_q});
				mul_b = $signed({1'b0, cfg.gate_ratio});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			clr_q       <= '0;
			dc_q        <= '0;
			sum_q       <= '0;
			floor_q     <= FLOOR_MAX;
			gate_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (sample_out.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR:     clr_q <= clr_q + 1'b1;
				ST_TRACK_ADD: dc_q  <= dc_q + prod[DC_W+15:16];
				ST_EMIT: begin
					if (slot_free) begin
						if (is_last) begin
							idx_q <= '0;
							if (gate_on) begin
								sum_q <= sum_d;
							end else begin
								sum_q  <= '0;
								gate_q <= 1'b0;
							end
						end else begin
							idx_q <= idx_q + 1'b1;
							sum_q <= sum_d;
						end
					end
				end
				ST_DIV_GO: sum_q <= '0;
				ST_FLOOR: begin
					// The floor drops to a quieter frame at once.
					if (r16_w < floor_q) floor_q <= r16_w;
				end
				ST_CREEP:  floor_q <= floor_q + prod[FLOOR_W+15:16];
				ST_DECIDE: gate_q  <= (THR_W'(r24) < thr);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) raw_q <= sample_in.payload.raw_sample;
		if (state_q == ST_TRACK) old_q <= ram_rdata;
		if (state_q == ST_SCALE) clean_q <= y_sat;
		if (emit_fire) begin
			n_q                <= N_W'(idx_next);
			out_q.clean_sample <= gate_q ? '0 : $signed(old_q);
			out_q.gated        <= gate_q;
			out_q.frame_last   <= is_last;
		end
	end
endmodule

@@ rtl/core/mdng_ram.sv @@
// ----------------------------------------------------------------------------
// mdng_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mdng_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end
endmodule

@@ rtl/core/mdng_mul.sv @@
// ----------------------------------------------------------------------------
// mdng_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mdng_mul (
	input  logic                                 clk,
	input  logic signed [mdng_pkg::MUL_A_W-1:0] a,
	input  logic signed [mdng_pkg::MUL_B_W-1:0] b,
	output logic signed [mdng_pkg::PROD_W-1:0]  p_q
);
	import mdng_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end
endmodule

@@ rtl/core/mdng_root_div.sv @@
// ----------------------------------------------------------------------------
// mdng_root_div
// Iterative divide followed by integer square root on one shift-subtract unit.
// ----------------------------------------------------------------------------
module mdng_root_div #(
	parameter int N_W = 11
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [mdng_pkg::DIV_W-1:0]     dividend,
	input  logic [N_W-1:0]                 divisor,
	output logic                           idle,
	output logic [mdng_pkg::ROOT_W-1:0]    root
);
	import mdng_pkg::*;

	rd_phase_t           phase_q, phase_d;
	logic [CNT_W-1:0]    cnt_q;
	logic [SQ_W-1:0]     x_q;
	logic [REM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [N_W-1:0]      n_q;
	logic [REM_W-1:0]    pr, sub, diff, rem_n;
	logic                ge;

	// One compare-and-subtract serves both the quotient bit and the root bit.
	always_comb begin
		if (phase_q == RD_DIV) begin
			pr  = {rem_q[REM_W-2:0], x_q[DIV_W-1]};
			sub = REM_W'(n_q);
		end else begin
			pr  = {rem_q[REM_W-3:0], x_q[SQ_W-1 -: 2]};
			sub = {root_q, 2'b01};
		end
		ge    = (pr >= sub);
		diff  = pr - sub;
		rem_n = ge ? diff : pr;
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			RD_IDLE: if (start) phase_d = RD_DIV;
			RD_DIV:  if (cnt_q == '0) phase_d = RD_SQRT;
			RD_SQRT: if (cnt_q == '0) phase_d = RD_IDLE;
			default: phase_d = RD_IDLE;
		endcase
	end

	always_comb begin
		idle = (phase_q == RD_IDLE);
		root = root_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= RD_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			RD_IDLE: begin
				if (start) begin
					x_q   <= SQ_W'(dividend);
					rem_q <= '0;
					n_q   <= divisor;
					cnt_q <= CNT_W'(DIV_W - 1);
				end
			end
			RD_DIV: begin
				x_q <= {1'b0, x_q[DIV_W-2:0], ge};
				if (cnt_q == '0) begin
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= CNT_W'(ROOT_W - 1);
				end else begin
					rem_q <= rem_n;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			RD_SQRT: begin
				x_q    <= {x_q[SQ_W-3:0], 2'b00};
				rem_q  <= rem_n;
				root_q <= {root_q[ROOT_W-2:0], ge};
				cnt_q  <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end
endmodule

@@ rtl/core/mdng_apb.sv @@
// ----------------------------------------------------------------------------
// mdng_apb
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module mdng_apb (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mdng_pkg::ADDR_W-1:0] paddr,
	input  logic [mdng_pkg::DATA_W-1:0] pwdata,
	output logic [mdng_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output mdng_pkg::cfg_t              cfg
);
	import mdng_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	always_comb begin
		idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
		wr     = psel && penable && pwrite;
		pready = 1'b1;
		cfg    = cfg_q;
		prdata = '0;
		case (idx)
			REG_DC_COEF:      prdata = DATA_W'(cfg_q.dc_coef);
			REG_GAIN:         prdata = DATA_W'(cfg_q.gain);
			REG_GATE_RATIO:   prdata = DATA_W'(cfg_q.gate_ratio);
			REG_FLOOR_CREEP:  prdata = DATA_W'(cfg_q.floor_creep);
			REG_FRAME_LENGTH: prdata = DATA_W'(cfg_q.frame_length);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dc_coef      <= RST_DC_COEF;
			cfg_q.gain         <= RST_GAIN;
			cfg_q.gate_ratio   <= RST_GATE_RATIO;
			cfg_q.floor_creep  <= RST_FLOOR_CREEP;
			cfg_q.frame_length <= RST_FRAME_LEN;
		end else if (wr) begin
			case (idx)
				REG_DC_COEF:      cfg_q.dc_coef      <= pwdata[COEF_W-1:0];
				REG_GAIN:         cfg_q.gain         <= pwdata[COEF_W-1:0];
				REG_GATE_RATIO:   cfg_q.gate_ratio   <= pwdata[COEF_W-1:0];
				REG_FLOOR_CREEP:  cfg_q.floor_creep  <= pwdata[COEF_W-1:0];
				REG_FRAME_LENGTH: cfg_q.frame_length <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end
endmodule
